// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file edpd_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/edpd_pkg.sv =====
package edpd_pkg;

   localparam int POS_BITS_DEF = 24;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_CEIL    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_FLOOR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PROP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_DERIV    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADJUST_PERIOD = 3'd4;

   localparam logic [7:0]  POWER_CEIL_RST    = 8'd255;
   localparam logic [7:0]  POWER_FLOOR_RST   = 8'd0;
   localparam logic [15:0] GAIN_PROP_RST     = 16'd51;
   localparam logic [15:0] GAIN_DERIV_RST    = 16'd26;
   localparam logic [15:0] ADJUST_PERIOD_RST = 16'd100;

   localparam logic OP_SERVICE = 1'b0;
   localparam logic OP_START   = 1'b1;

   typedef enum logic [1:0] {
      DIR_BRAKE    = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2
   } dir_type;

   typedef struct packed {
      logic [7:0]  power_ceil;
      logic [7:0]  power_floor;
      logic [15:0] gain_prop_q8;
      logic [15:0] gain_deriv_q8;
      logic [15:0] adjust_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [7:0] speed_right;
      logic [7:0] speed_left;
      dir_type    dir_right;
      dir_type    dir_left;
      logic       reached;
      logic       clear_encoders;
   } rsp_type;

endpackage

// ===== hw/rtl/edpd_csr.sv =====
module edpd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [edpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [edpd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output edpd_pkg::cfg_type                 cfg
);

   edpd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            edpd_pkg::CSR_POWER_CEIL:    cfg_in.power_ceil       = csr_wdata[7:0];
            edpd_pkg::CSR_POWER_FLOOR:   cfg_in.power_floor      = csr_wdata[7:0];
            edpd_pkg::CSR_GAIN_PROP:     cfg_in.gain_prop_q8     = csr_wdata;
            edpd_pkg::CSR_GAIN_DERIV:    cfg_in.gain_deriv_q8    = csr_wdata;
            edpd_pkg::CSR_ADJUST_PERIOD: cfg_in.adjust_period_ms = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_ceil       <= edpd_pkg::POWER_CEIL_RST;
         cfg_ff.power_floor      <= edpd_pkg::POWER_FLOOR_RST;
         cfg_ff.gain_prop_q8     <= edpd_pkg::GAIN_PROP_RST;
         cfg_ff.gain_deriv_q8    <= edpd_pkg::GAIN_DERIV_RST;
         cfg_ff.adjust_period_ms <= edpd_pkg::ADJUST_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/edpd_core.sv =====
module edpd_core #(
   parameter int POS_BITS = edpd_pkg::POS_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  edpd_pkg::cfg_type          cfg,
   input  logic                       opcode,
   input  logic signed [POS_BITS-1:0] goal_right,
   input  logic signed [POS_BITS-1:0] goal_left,
   input  logic [7:0]                 start_power,
   input  logic signed [POS_BITS-1:0] pos_right,
   input  logic signed [POS_BITS-1:0] pos_left,
   input  logic [31:0]                now_ms,
   output edpd_pkg::rsp_type          rsp
);

   localparam int PW  = POS_BITS + 1;   // folded position / saturated error
   localparam int DW  = POS_BITS + 2;   // raw error and error delta
   localparam int PPW = PW + 17;        // proportional product
   localparam int PDW = DW + 17;        // derivative product
   localparam int SW  = PDW + 1;        // product sum
   localparam int OW  = SW - 8;         // offset after the Q8 shift
   localparam logic signed [DW-1:0] ERR_HI = $signed({2'b00, {POS_BITS{1'b1}}});
   localparam logic signed [DW-1:0] ERR_LO = $signed({2'b11, {POS_BITS{1'b0}}});

   logic signed [POS_BITS-1:0] target_right_ff, target_right_in;
   logic signed [POS_BITS-1:0] target_left_ff, target_left_in;
   logic signed [PW-1:0]       prev_err_ff, prev_err_in;
   logic [7:0]                 power_right_ff, power_right_in;
   logic [7:0]                 power_left_ff, power_left_in;
   logic [31:0]                last_adjust_ff, last_adjust_in;
   logic                       done_ff, done_in;

   logic                       start_take;
   logic signed [POS_BITS-1:0] tr_sel, tl_sel, pr_sel, pl_sel;
   logic signed [PW-1:0]       prev_sel;
   logic [7:0]                 pwr_r_sel, pwr_l_sel;
   logic signed [PW-1:0]       tr_x, tl_x, pr_x, pl_x;
   logic signed [PW-1:0]       tr_abs, tl_abs, fr, fl;
   logic                       hit, due;
   logic [31:0]                due_ms;
   logic signed [DW-1:0]       err_raw, err_sat, diff;
   logic signed [PW-1:0]       err;
   logic signed [16:0]         gp_s, gd_s;
   logic signed [PPW-1:0]      prod_p;
   logic signed [PDW-1:0]      prod_d;
   logic signed [SW-1:0]       sum, sum_b;
   logic signed [OW-1:0]       off;
   logic signed [OW:0]         nl, nr;
   logic signed [OW:0]         max_x, min_x, pl_w, pr_w;
   logic                       left_out;
   logic [7:0]                 nr_sat;

   always_comb begin
      start_take = (opcode == edpd_pkg::OP_START) && done_ff;
      tr_sel     = start_take ? goal_right : target_right_ff;
      tl_sel     = start_take ? goal_left : target_left_ff;
      pr_sel     = start_take ? '0 : pos_right;
      pl_sel     = start_take ? '0 : pos_left;
      prev_sel   = start_take ? '0 : prev_err_ff;
      pwr_r_sel  = start_take ? start_power : power_right_ff;
      pwr_l_sel  = start_take ? start_power : power_left_ff;

      // fold each wheel by the sign of its own target
      tr_x   = PW'(tr_sel);
      tl_x   = PW'(tl_sel);
      pr_x   = PW'(pr_sel);
      pl_x   = PW'(pl_sel);
      tr_abs = tr_sel[POS_BITS-1] ? -tr_x : tr_x;
      tl_abs = tl_sel[POS_BITS-1] ? -tl_x : tl_x;
      fr     = tr_sel[POS_BITS-1] ? -pr_x : pr_x;
      fl     = tl_sel[POS_BITS-1] ? -pl_x : pl_x;
      hit    = (fl >= tl_abs) || (fr >= tr_abs);

      due_ms = last_adjust_ff + {16'd0, cfg.adjust_period_ms};
      due    = now_ms > due_ms;

      err_raw = DW'(fr) - DW'(fl);
      if (err_raw > ERR_HI) begin
         err_sat = ERR_HI;
      end else if (err_raw < ERR_LO) begin
         err_sat = ERR_LO;
      end else begin
         err_sat = err_raw;
      end
      err  = err_sat[PW-1:0];
      diff = DW'(err) - DW'(prev_sel);

      gp_s   = $signed({1'b0, cfg.gain_prop_q8});
      gd_s   = $signed({1'b0, cfg.gain_deriv_q8});
      prod_p = err * gp_s;
      prod_d = diff * gd_s;
      sum    = SW'(prod_p) + SW'(prod_d);
      // bias negative sums so the shift truncates toward zero
      sum_b  = sum + (sum[SW-1] ? SW'(255) : SW'(0));
      off    = sum_b[SW-1:8];

      pl_w  = $signed({{(OW-7){1'b0}}, pwr_l_sel});
      pr_w  = $signed({{(OW-7){1'b0}}, pwr_r_sel});
      max_x = $signed({{(OW-7){1'b0}}, cfg.power_ceil});
      min_x = $signed({{(OW-7){1'b0}}, cfg.power_floor});
      nl    = pl_w + (OW+1)'(off);
      nr    = pr_w - (OW+1)'(off);
      left_out = (nl > max_x) || (nl < min_x);
      if (nr < 0) begin
         nr_sat = 8'd0;
      end else if (nr > (OW+1)'(255)) begin
         nr_sat = 8'd255;
      end else begin
         nr_sat = nr[7:0];
      end

      target_right_in = tr_sel;
      target_left_in  = tl_sel;
      prev_err_in     = prev_sel;
      power_right_in  = pwr_r_sel;
      power_left_in   = pwr_l_sel;
      last_adjust_in  = last_adjust_ff;
      done_in         = start_take ? 1'b0 : done_ff;
      if (hit) begin
         done_in = 1'b1;
      end else if (due) begin
         prev_err_in    = err;
         last_adjust_in = now_ms;
         if (left_out) begin
            power_right_in = nr_sat;
         end else begin
            power_left_in = nl[7:0];
         end
      end
   end

   always_comb begin
      rsp.clear_encoders = start_take;
      if (done_in) begin
         rsp.speed_right = 8'd0;
         rsp.speed_left  = 8'd0;
         rsp.dir_right   = edpd_pkg::DIR_BRAKE;
         rsp.dir_left    = edpd_pkg::DIR_BRAKE;
         rsp.reached     = 1'b1;
      end else begin
         rsp.speed_right = power_right_in;
         rsp.speed_left  = power_left_in;
         rsp.dir_right   = tr_sel[POS_BITS-1] ? edpd_pkg::DIR_BACKWARD : edpd_pkg::DIR_FORWARD;
         rsp.dir_left    = tl_sel[POS_BITS-1] ? edpd_pkg::DIR_BACKWARD : edpd_pkg::DIR_FORWARD;
         rsp.reached     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_right_ff <= '0;
         target_left_ff  <= '0;
         prev_err_ff     <= '0;
         power_right_ff  <= 8'd0;
         power_left_ff   <= 8'd0;
         last_adjust_ff  <= 32'd0;
         done_ff         <= 1'b1;
      end else if (step) begin
         target_right_ff <= target_right_in;
         target_left_ff  <= target_left_in;
         prev_err_ff     <= prev_err_in;
         power_right_ff  <= power_right_in;
         power_left_ff   <= power_left_in;
         last_adjust_ff  <= last_adjust_in;
         done_ff         <= done_in;
      end
   end

endmodule

// ===== hw/rtl/encoder_drive_pd_controller_unit.sv =====
// Two-wheel move controller. A transaction with opcode start (accepted only
// once the previous move has reached its target) loads signed tick targets
// and one start power for both wheels and raises clear_encoders in its
// result; every transaction then compares the encoder positions with the
// targets, brakes and reports reached when either wheel is there, and
// otherwise, once adjust_period_ms has passed, trims the left power (or the
// right one, if left would leave power_floor..power_ceil) by a PD offset
// with Q8.8 gains. One transaction per clock unless the result stalls;
// one input register and one result register. The PD multiply-add and move
// state update are combinational between them, so every request sees the
// state left by the one before it. A stalled result holds; one further
// request is still taken into the input register meanwhile. Configuration
// writes take effect at the next edge and should be made while idle.
module encoder_drive_pd_controller_unit #(
   parameter int POS_BITS = edpd_pkg::POS_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic signed [POS_BITS-1:0]        req_goal_right,
   input  logic signed [POS_BITS-1:0]        req_goal_left,
   input  logic [7:0]                        req_start_power,
   input  logic signed [POS_BITS-1:0]        req_pos_right,
   input  logic signed [POS_BITS-1:0]        req_pos_left,
   input  logic [31:0]                       req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_speed_right,
   output logic [7:0]                        rsp_speed_left,
   output logic [1:0]                        rsp_dir_right,
   output logic [1:0]                        rsp_dir_left,
   output logic                              rsp_reached,
   output logic                              rsp_clear_encoders,
   input  logic                              csr_we,
   input  logic [edpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [edpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   edpd_pkg::cfg_type cfg;
   edpd_pkg::rsp_type core_rsp;
   edpd_pkg::rsp_type rsp_ff;

   logic                       in_valid_ff, in_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       in_opcode_ff;
   logic signed [POS_BITS-1:0] in_goal_right_ff, in_goal_left_ff;
   logic [7:0]                 in_start_power_ff;
   logic signed [POS_BITS-1:0] in_pos_right_ff, in_pos_left_ff;
   logic [31:0]                in_now_ms_ff;
   logic                       accept, advance;

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   edpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   edpd_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .cfg         (cfg),
      .opcode      (in_opcode_ff),
      .goal_right  (in_goal_right_ff),
      .goal_left   (in_goal_left_ff),
      .start_power (in_start_power_ff),
      .pos_right   (in_pos_right_ff),
      .pos_left    (in_pos_left_ff),
      .now_ms      (in_now_ms_ff),
      .rsp         (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_opcode_ff      <= req_opcode;
         in_goal_right_ff  <= req_goal_right;
         in_goal_left_ff   <= req_goal_left;
         in_start_power_ff <= req_start_power;
         in_pos_right_ff   <= req_pos_right;
         in_pos_left_ff    <= req_pos_left;
         in_now_ms_ff      <= req_now_ms;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_speed_right    = rsp_ff.speed_right;
   assign rsp_speed_left     = rsp_ff.speed_left;
   assign rsp_dir_right      = rsp_ff.dir_right;
   assign rsp_dir_left       = rsp_ff.dir_left;
   assign rsp_reached        = rsp_ff.reached;
   assign rsp_clear_encoders = rsp_ff.clear_encoders;

endmodule

// ===== hw/rtl/edpd_checker.sv =====
`include "assert_macros.svh"

module edpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_speed_right,
   input logic [7:0] rsp_speed_left,
   input logic [1:0] rsp_dir_right,
   input logic [1:0] rsp_dir_left,
   input logic       rsp_reached,
   input logic       rsp_clear_encoders
);

   logic        done_shown, run_shown, stalled, brake_all, dirs_driven;
   logic [21:0] rsp_bits;

   assign done_shown  = rsp_valid && rsp_reached;
   assign run_shown   = rsp_valid && !rsp_reached;
   assign stalled     = rsp_valid && rsp_stall;
   assign brake_all   = (rsp_speed_right == 8'd0) && (rsp_speed_left == 8'd0) &&
                        (rsp_dir_right == edpd_pkg::DIR_BRAKE) &&
                        (rsp_dir_left == edpd_pkg::DIR_BRAKE);
   assign dirs_driven = ((rsp_dir_right == edpd_pkg::DIR_FORWARD) ||
                         (rsp_dir_right == edpd_pkg::DIR_BACKWARD)) &&
                        ((rsp_dir_left == edpd_pkg::DIR_FORWARD) ||
                         (rsp_dir_left == edpd_pkg::DIR_BACKWARD));
   assign rsp_bits    = {rsp_speed_right, rsp_speed_left, rsp_dir_right, rsp_dir_left,
                         rsp_reached, rsp_clear_encoders};

   // a finished move always reports zero speed and brake on both wheels
   `ASSERT_IMP(a_reached_brakes, clock, reset, done_shown, brake_all, "reached without brake")

   // a running move drives both wheels one way or the other
   `ASSERT_IMP(a_running_dirs, clock, reset, run_shown, dirs_driven, "running with brake")

   // a stalled result stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_bits), "result moved")

   // nothing comes out right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind encoder_drive_pd_controller_unit edpd_checker u_edpd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_speed_right    (rsp_speed_right),
   .rsp_speed_left     (rsp_speed_left),
   .rsp_dir_right      (rsp_dir_right),
   .rsp_dir_left       (rsp_dir_left),
   .rsp_reached        (rsp_reached),
   .rsp_clear_encoders (rsp_clear_encoders)
);

// ===== bench/tb_encoder_drive_pd_controller_unit.sv =====
module tb_encoder_drive_pd_controller_unit;

   localparam int POS_W        = edpd_pkg::POS_BITS_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1080;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_opcode;
   logic signed [POS_W-1:0]             req_goal_right;
   logic signed [POS_W-1:0]             req_goal_left;
   logic [7:0]                          req_start_power;
   logic signed [POS_W-1:0]             req_pos_right;
   logic signed [POS_W-1:0]             req_pos_left;
   logic [31:0]                         req_now_ms;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [7:0]                          rsp_speed_right;
   logic [7:0]                          rsp_speed_left;
   logic [1:0]                          rsp_dir_right;
   logic [1:0]                          rsp_dir_left;
   logic                                rsp_reached;
   logic                                rsp_clear_encoders;
   logic                                csr_we;
   logic [edpd_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [edpd_pkg::CSR_DATA_W-1:0]     csr_wdata;

   encoder_drive_pd_controller_unit #(.POS_BITS(POS_W)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_goal_right     (req_goal_right),
      .req_goal_left      (req_goal_left),
      .req_start_power    (req_start_power),
      .req_pos_right      (req_pos_right),
      .req_pos_left       (req_pos_left),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_speed_right    (rsp_speed_right),
      .rsp_speed_left     (rsp_speed_left),
      .rsp_dir_right      (rsp_dir_right),
      .rsp_dir_left       (rsp_dir_left),
      .rsp_reached        (rsp_reached),
      .rsp_clear_encoders (rsp_clear_encoders),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // controller model state
   edpd_pkg::cfg_type       drive_cfg = '{edpd_pkg::POWER_CEIL_RST, edpd_pkg::POWER_FLOOR_RST,
                                          edpd_pkg::GAIN_PROP_RST, edpd_pkg::GAIN_DERIV_RST,
                                          edpd_pkg::ADJUST_PERIOD_RST};
   logic signed [POS_W-1:0] tgt_right = '0;
   logic signed [POS_W-1:0] tgt_left  = '0;
   longint                  prev_err  = 0;
   logic [7:0]              pwr_right = '0;
   logic [7:0]              pwr_left  = '0;
   logic [31:0]             last_adj  = '0;
   logic                    move_done = 1'b1;

   edpd_pkg::rsp_type pending_drive_q[$];
   int                fail_count  = 0;
   int                items_sent  = 0;
   int                cycle_count = 0;
   bit                quiet_mode  = 1'b0;
   logic [31:0]       wall_ms     = '0;

   function automatic edpd_pkg::rsp_type predict_drive(input logic op,
         input logic signed [POS_W-1:0] goal_r, goal_l, input logic [7:0] power,
         input logic signed [POS_W-1:0] pos_r, pos_l, input logic [31:0] now);
      longint            fr, fl, tr, tl, err, off, next_l, next_r, lim;
      logic [31:0]       due;
      logic              clr;
      edpd_pkg::rsp_type r;
      fr  = longint'(pos_r);
      fl  = longint'(pos_l);
      clr = 1'b0;
      if (op == edpd_pkg::OP_START && move_done) begin
         tgt_right = goal_r;
         tgt_left  = goal_l;
         pwr_right = power;
         pwr_left  = power;
         prev_err  = 0;
         move_done = 1'b0;
         clr       = 1'b1;
         // encoders are being cleared by this transaction
         fr = 0;
         fl = 0;
      end
      tr = longint'(tgt_right);
      tl = longint'(tgt_left);
      if (tr < 0) begin
         fr = -fr;
         tr = -tr;
      end
      if (tl < 0) begin
         fl = -fl;
         tl = -tl;
      end
      due = last_adj + {16'd0, drive_cfg.adjust_period_ms};
      if (fl >= tl || fr >= tr) begin
         move_done = 1'b1;
      end else if (now > due) begin
         lim = longint'(1) <<< POS_W;
         err = fr - fl;
         if (err > lim - 1) err = lim - 1;
         if (err < -lim) err = -lim;
         off = (err * longint'(drive_cfg.gain_prop_q8) +
                (err - prev_err) * longint'(drive_cfg.gain_deriv_q8)) / 256;
         prev_err = err;
         last_adj = now;
         next_l   = longint'(pwr_left) + off;
         if (next_l > longint'(drive_cfg.power_ceil) ||
             next_l < longint'(drive_cfg.power_floor)) begin
            next_r = longint'(pwr_right) - off;
            if (next_r < 0) next_r = 0;
            if (next_r > 255) next_r = 255;
            pwr_right = next_r[7:0];
         end else begin
            pwr_left = next_l[7:0];
         end
      end
      if (move_done) begin
         r.speed_right = '0;
         r.speed_left  = '0;
         r.dir_right   = edpd_pkg::DIR_BRAKE;
         r.dir_left    = edpd_pkg::DIR_BRAKE;
         r.reached     = 1'b1;
      end else begin
         r.speed_right = pwr_right;
         r.speed_left  = pwr_left;
         r.dir_right   = (tgt_right < 0) ? edpd_pkg::DIR_BACKWARD : edpd_pkg::DIR_FORWARD;
         r.dir_left    = (tgt_left < 0) ? edpd_pkg::DIR_BACKWARD : edpd_pkg::DIR_FORWARD;
         r.reached     = 1'b0;
      end
      r.clear_encoders = clr;
      return r;
   endfunction

   always @(posedge clock) begin
      edpd_pkg::rsp_type want;
      if (quiet_mode) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 22);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive_q.size() == 0) begin
            $error("result transaction with nothing pending");
            fail_count++;
         end else begin
            want = pending_drive_q.pop_front();
            if (rsp_speed_right !== want.speed_right) begin
               $error("speed_right: expected %0d, actual %0d", want.speed_right,
                      rsp_speed_right);
               fail_count++;
            end
            if (rsp_speed_left !== want.speed_left) begin
               $error("speed_left: expected %0d, actual %0d", want.speed_left,
                      rsp_speed_left);
               fail_count++;
            end
            if (rsp_dir_right !== want.dir_right) begin
               $error("dir_right: expected %0d, actual %0d", want.dir_right,
                      rsp_dir_right);
               fail_count++;
            end
            if (rsp_dir_left !== want.dir_left) begin
               $error("dir_left: expected %0d, actual %0d", want.dir_left, rsp_dir_left);
               fail_count++;
            end
            if (rsp_reached !== want.reached) begin
               $error("reached: expected %0d, actual %0d", want.reached, rsp_reached);
               fail_count++;
            end
            if (rsp_clear_encoders !== want.clear_encoders) begin
               $error("clear_encoders: expected %0d, actual %0d", want.clear_encoders,
                      rsp_clear_encoders);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_item(input logic op,
         input logic signed [POS_W-1:0] goal_r, goal_l, input logic [7:0] power,
         input logic signed [POS_W-1:0] pos_r, pos_l, input logic [31:0] now);
      while (!quiet_mode && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_goal_right  <= goal_r;
      req_goal_left   <= goal_l;
      req_start_power <= power;
      req_pos_right   <= pos_r;
      req_pos_left    <= pos_l;
      req_now_ms      <= now;
      do @(posedge clock); while (req_stall);
      pending_drive_q.push_back(predict_drive(op, goal_r, goal_l, power, pos_r, pos_l, now));
      items_sent++;
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_drive_q.size() != 0);
   endtask

   // upper bits of the 8-bit registers carry junk on purpose
   task automatic apply_config(input edpd_pkg::cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= edpd_pkg::CSR_POWER_CEIL;
      csr_wdata <= {8'($urandom), c.power_ceil};
      @(posedge clock);
      csr_index <= edpd_pkg::CSR_POWER_FLOOR;
      csr_wdata <= {8'($urandom), c.power_floor};
      @(posedge clock);
      csr_index <= edpd_pkg::CSR_GAIN_PROP;
      csr_wdata <= c.gain_prop_q8;
      @(posedge clock);
      csr_index <= edpd_pkg::CSR_GAIN_DERIV;
      csr_wdata <= c.gain_deriv_q8;
      @(posedge clock);
      csr_index <= edpd_pkg::CSR_ADJUST_PERIOD;
      csr_wdata <= c.adjust_period_ms;
      @(posedge clock);
      csr_we    <= 1'b0;
      drive_cfg = c;
   endtask

   function automatic longint fit_pos(input longint p);
      longint hi;
      hi = (longint'(1) <<< (POS_W - 1)) - 1;
      if (p > hi) return hi;
      if (p < -hi - 1) return -hi - 1;
      return p;
   endfunction

   function automatic longint pick_goal();
      int     sel;
      longint mag;
      sel = int'($urandom_range(99));
      if (sel < 4) return -(longint'(1) <<< (POS_W - 1));
      if (sel < 8) return (longint'(1) <<< (POS_W - 1)) - 1;
      if (sel < 12) return 0;
      if (sel < 20) mag = longint'($urandom_range(1, 8388607));
      else mag = longint'($urandom_range(1, 3000));
      return $urandom_range(1) ? mag : -mag;
   endfunction

   function automatic longint step_toward(input longint goal, input int div);
      longint mag;
      mag = ((goal < 0) ? -goal : goal) / longint'(div) +
            longint'($urandom_range(0, 3)) - 1;
      return (goal < 0) ? -mag : mag;
   endfunction

   // one well-formed move: start, encoder progress, then a closing update
   task automatic run_move(input int max_steps);
      longint goal_r, goal_l, pos_r, pos_l;
      int     div_r, div_l, n, extra;
      goal_r = pick_goal();
      if ($urandom_range(99) < 75) begin
         goal_l = fit_pos(goal_r + longint'($urandom_range(0, 40)) - 20);
      end else begin
         goal_l = pick_goal();
      end
      send_item(edpd_pkg::OP_START, POS_W'(goal_r), POS_W'(goal_l), 8'($urandom),
                POS_W'($urandom), POS_W'($urandom), wall_ms);
      // a stray start may have loaded other targets
      goal_r = longint'(tgt_right);
      goal_l = longint'(tgt_left);
      pos_r  = 0;
      pos_l  = 0;
      div_r  = int'($urandom_range(3, 20));
      div_l  = int'($urandom_range(3, 20));
      n      = 0;
      while (!move_done && n < max_steps) begin
         pos_r   = fit_pos(pos_r + step_toward(goal_r, div_r));
         pos_l   = fit_pos(pos_l + step_toward(goal_l, div_l));
         wall_ms += $urandom_range(0, 160);
         if ($urandom_range(99) < 3) wall_ms = $urandom;
         send_item(($urandom_range(99) < 5) ? edpd_pkg::OP_START : edpd_pkg::OP_SERVICE,
                   POS_W'($urandom), POS_W'($urandom), 8'($urandom), POS_W'(pos_r),
                   POS_W'(pos_l), wall_ms);
         n++;
      end
      if (!move_done)
         send_item(edpd_pkg::OP_SERVICE, POS_W'($urandom), POS_W'($urandom), 8'($urandom),
                   tgt_right, tgt_left, wall_ms);
      // done, but encoders fall back short of target
      extra = ($urandom_range(99) < 30) ? int'($urandom_range(1, 3)) : 0;
      repeat (extra) begin
         wall_ms += $urandom_range(50, 400);
         send_item(edpd_pkg::OP_SERVICE, POS_W'($urandom), POS_W'($urandom), 8'($urandom),
                   POS_W'(longint'($urandom_range(0, 20)) - 10),
                   POS_W'(longint'($urandom_range(0, 20)) - 10), wall_ms);
      end
   endtask

   task automatic test_directed_moves();
      wait_for_idle();
      apply_config('{edpd_pkg::POWER_CEIL_RST, edpd_pkg::POWER_FLOOR_RST,
                     edpd_pkg::GAIN_PROP_RST, edpd_pkg::GAIN_DERIV_RST,
                     edpd_pkg::ADJUST_PERIOD_RST});
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 8388607, -8388608, 0);
      // encoders of a start transaction count as zero
      send_item(edpd_pkg::OP_START, 1000, 1000, 128, 5000, -77, 50);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 300, 100, 150);
      send_item(edpd_pkg::OP_START, -5, -5, 9, 300, 100, 160);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 310, 600, 300);
      // left leaves range: right takes it and saturates high, then low
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 0, 900, 500);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 900, 0, 700);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 999, 1000, 710);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, -5, -5, 1000);
      send_item(edpd_pkg::OP_START, -8388608, 8388607, 255, 0, 0, 1001);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, -8388608, 0, 32'hFFFF_FFFF);
      send_item(edpd_pkg::OP_START, 0, 500, 0, 1, 1, 2);
      send_item(edpd_pkg::OP_START, -700, -700, 77, 0, 0, 5);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 8388607, 8388607, 2000);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, -300, -650, 32'hFFFF_FFF0);
      // adjust deadline wraps past zero
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, -310, -660, 32'h0000_0060);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, -700, -100, 32'h0000_0070);
   endtask

   task automatic test_inverted_limits();
      wait_for_idle();
      apply_config('{8'd10, 8'd200, 16'd51, 16'd26, 16'd100});
      send_item(edpd_pkg::OP_START, 400, 400, 100, 0, 0, 32'h0000_0100);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 50, 10, 32'h0000_1000);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 60, 200, 32'h0000_2000);
      send_item(edpd_pkg::OP_SERVICE, 0, 0, 0, 400, 400, 32'h0000_3000);
   endtask

   task automatic test_random_moves();
      edpd_pkg::cfg_type plan [6];
      int                goal_count;
      plan[0] = '{edpd_pkg::POWER_CEIL_RST, edpd_pkg::POWER_FLOOR_RST,
                  edpd_pkg::GAIN_PROP_RST, edpd_pkg::GAIN_DERIV_RST,
                  edpd_pkg::ADJUST_PERIOD_RST};
      plan[1] = '{8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'd0};
      plan[2] = '{8'd200, 8'd30, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 300))};
      plan[3] = '{8'd255, 8'd0, 16'd0, 16'd0, 16'hFFFF};
      plan[4] = '{8'($urandom), 8'($urandom), 16'($urandom_range(0, 2048)),
                  16'($urandom_range(0, 2048)), 16'($urandom_range(0, 500))};
      plan[5] = '{8'd128, 8'd128, 16'd256, 16'd512, 16'd1};
      foreach (plan[k]) begin
         wait_for_idle();
         apply_config(plan[k]);
         // one phase runs without random request gaps or result stalls
         quiet_mode = (k == 2);
         goal_count = items_sent + RANDOM_ITEMS / 6;
         while (items_sent < goal_count) begin
            if ($urandom_range(99) < 10)
               send_item(1'($urandom_range(1)), POS_W'($urandom), POS_W'($urandom),
                         8'($urandom), POS_W'($urandom), POS_W'($urandom), $urandom);
            else
               run_move(int'($urandom_range(4, 40)));
            if ($urandom_range(99) < 5) wait_for_idle();
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= edpd_pkg::OP_SERVICE;
      req_goal_right  <= '0;
      req_goal_left   <= '0;
      req_start_power <= '0;
      req_pos_right   <= '0;
      req_pos_left    <= '0;
      req_now_ms      <= '0;
      csr_we          <= 1'b0;
      csr_index       <= edpd_pkg::CSR_POWER_CEIL;
      csr_wdata       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_moves();
      test_inverted_limits();
      test_random_moves();
      wait_for_idle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
